FILE: hw/rtl/pwl_pkg.sv
// Shared types and constants for the piecewise-linear path evaluator.
package pwl_pkg;

  localparam int COORD_W = 32;
  localparam int POS_W   = 40;
  localparam int TOL_W   = 16;
  localparam int LEN_W   = 34;
  localparam int MACC_W  = 68;

  typedef logic [2:0][COORD_W-1:0] vec3_t;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_EVAL   = 2'd1,
    OP_LOCATE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_ON_PATH = 2'd1,
    ST_SHORT       = 2'd2,
    ST_FULL        = 2'd3
  } status_t;

  typedef enum logic [1:0] {RD_ZERO, RD_LAST, RD_IDX, RD_NEXT} rd_sel_t;
  typedef enum logic [1:0] {RES_NONE, RES_COORD, RES_LERP, RES_FOUND} res_kind_t;
  typedef enum logic {AR_DIST, AR_LERP} arith_op_t;
  typedef enum logic [1:0] {AP_IDLE, AP_MUL, AP_SQRT, AP_DIV} arith_ph_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_APP, S_APP_RD, S_APP_GO, S_APP_WT,
    S_EV_WALK, S_EV_A, S_EV_B, S_EV_GO, S_EV_WT, S_EV_END,
    S_LC_P0, S_LC_D0, S_LC_W0, S_LC_RL, S_LC_RC, S_LC_LD, S_LC_GO, S_LC_WT,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic      cap_in;
    logic      clr_path;
    logic      wr_kf;
    logic      wr_len;
    logic      cnt_inc;
    rd_sel_t   rd_sel;
    logic      ld_pa_q;
    logic      ld_pa_rd;
    logic      ld_pb_q;
    logic      ld_pb_rd;
    logic      arith_start;
    arith_op_t arith_op;
    logic      idx_clr;
    logic      idx_inc;
    logic      acc_clr;
    logic      acc_add_rd;
    logic      acc_add_seg;
    logic      seg_ld;
    logic      off_ld;
    logic      d1_ld;
    logic      res_ld;
    res_kind_t res_kind;
    status_t   res_status;
    logic      out_ld;
  } pwl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic restart;
    logic cnt_full;
    logic cnt_zero;
    logic cnt_lt2;
    logic t_zero;
    logic t_ge_total;
    logic ev_hit;
    logic on_seg;
    logic last_seg;
    logic arith_done;
  } pwl_sts_t;

endpackage

FILE: hw/rtl/pwl_arith.sv
// Sequential arithmetic unit: 3-D distance (multiply + sqrt) and per-axis interpolation.
module pwl_arith (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  pwl_pkg::arith_op_t                op,
  input  pwl_pkg::vec3_t                    pa,
  input  pwl_pkg::vec3_t                    pb,
  input  logic [pwl_pkg::LEN_W-1:0]         off,
  input  logic [pwl_pkg::LEN_W-1:0]         len,
  output logic                              done,
  output logic [pwl_pkg::LEN_W-1:0]         dist_out,
  output pwl_pkg::vec3_t                    lerp
);

  localparam logic [1:0] AX_LAST = 2'd2;

  pwl_pkg::arith_ph_t ph_r;
  pwl_pkg::arith_op_t op_r;
  logic                            done_r;
  logic [1:0]                      ax_r;
  logic                            part_r;
  logic [5:0]                      cnt_r;
  logic [pwl_pkg::MACC_W-1:0]      macc_r;
  logic [35:0]                     sq_rem_r;
  logic [33:0]                     root_r;
  logic [33:0]                     dv_rem_r;
  logic [32:0]                     q_r;
  pwl_pkg::vec3_t                  res_r;

  logic [31:0] pa_ax, pb_ax;
  logic [32:0] diff, mag;
  logic        neg;
  logic [34:0] mul_b;
  logic [17:0] part_b;
  logic [50:0] prod;
  logic [pwl_pkg::MACC_W-1:0] addend, msum;
  logic [37:0] rem_n, trial, sq_sub;
  logic        sq_ge;
  logic [34:0] r2, dv_sub;
  logic        dv_ge;
  logic [32:0] q_fin;
  logic [33:0] qx, lsum;

  always_comb begin
    pa_ax  = pa[ax_r];
    pb_ax  = pb[ax_r];
    diff   = {pb_ax[31], pb_ax} - {pa_ax[31], pa_ax};
    neg    = diff[32];
    mag    = neg ? (~diff + 33'd1) : diff;
    mul_b  = (op_r == pwl_pkg::AR_DIST) ? {2'b00, mag} : {1'b0, off};
    part_b = part_r ? {1'b0, mul_b[34:18]} : mul_b[17:0];
    prod   = mag * part_b;
    addend = part_r ? {prod[49:0], 18'b0} : {17'b0, prod};
    msum   = macc_r + addend;
    rem_n  = {sq_rem_r, macc_r[67:66]};
    trial  = {2'b00, root_r, 2'b01};
    sq_ge  = rem_n >= trial;
    sq_sub = rem_n - trial;
    r2     = {dv_rem_r, macc_r[32]};
    dv_ge  = r2 >= {1'b0, len};
    dv_sub = r2 - {1'b0, len};
    q_fin  = {q_r[31:0], dv_ge};
    qx     = neg ? (~{1'b0, q_fin} + 34'd1) : {1'b0, q_fin};
    lsum   = {{2{pa_ax[31]}}, pa_ax} + qx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= pwl_pkg::AP_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (ph_r)
        pwl_pkg::AP_IDLE: begin
          if (start) begin
            ph_r   <= pwl_pkg::AP_MUL;
            op_r   <= op;
            ax_r   <= 2'd0;
            part_r <= 1'b0;
            macc_r <= '0;
          end
        end
        pwl_pkg::AP_MUL: begin
          macc_r <= msum;
          part_r <= ~part_r;
          if (part_r) begin
            if (op_r == pwl_pkg::AR_LERP) begin
              ph_r     <= pwl_pkg::AP_DIV;
              dv_rem_r <= msum[66:33];
              q_r      <= '0;
              cnt_r    <= 6'd32;
            end else if (ax_r == AX_LAST) begin
              ph_r     <= pwl_pkg::AP_SQRT;
              sq_rem_r <= '0;
              root_r   <= '0;
              cnt_r    <= 6'd33;
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end
        end
        pwl_pkg::AP_SQRT: begin
          sq_rem_r <= sq_ge ? sq_sub[35:0] : rem_n[35:0];
          root_r   <= {root_r[32:0], sq_ge};
          macc_r   <= {macc_r[65:0], 2'b00};
          cnt_r    <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            ph_r   <= pwl_pkg::AP_IDLE;
            done_r <= 1'b1;
          end
        end
        pwl_pkg::AP_DIV: begin
          dv_rem_r <= dv_ge ? dv_sub[33:0] : r2[33:0];
          q_r      <= q_fin;
          macc_r   <= {macc_r[66:0], 1'b0};
          cnt_r    <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            res_r[ax_r] <= lsum[31:0];
            if (ax_r == AX_LAST) begin
              ph_r   <= pwl_pkg::AP_IDLE;
              done_r <= 1'b1;
            end else begin
              ph_r   <= pwl_pkg::AP_MUL;
              ax_r   <= ax_r + 2'd1;
              part_r <= 1'b0;
              macc_r <= '0;
            end
          end
        end
        default: ph_r <= pwl_pkg::AP_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign dist_out = root_r;
  assign lerp     = res_r;

endmodule

FILE: hw/rtl/pwl_dp.sv
// Datapath: keyframe and segment memories, path registers, result and output registers.
module pwl_dp #(
  parameter int MAX_KEYFRAMES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pwl_pkg::pwl_cmd_t                cmd,
  output pwl_pkg::pwl_sts_t                sts,
  input  logic [1:0]                       in_opcode,
  input  logic                             in_restart,
  input  logic [pwl_pkg::COORD_W-1:0]      in_coord_x,
  input  logic [pwl_pkg::COORD_W-1:0]      in_coord_y,
  input  logic [pwl_pkg::COORD_W-1:0]      in_coord_z,
  input  logic [pwl_pkg::POS_W-1:0]        in_arc_position,
  input  logic                             cfg_we,
  input  logic [pwl_pkg::TOL_W-1:0]        cfg_tol,
  output logic [pwl_pkg::COORD_W-1:0]      out_point_x,
  output logic [pwl_pkg::COORD_W-1:0]      out_point_y,
  output logic [pwl_pkg::COORD_W-1:0]      out_point_z,
  output logic [pwl_pkg::POS_W-1:0]        out_found_position,
  output logic [1:0]                       out_status
);

  localparam int CNT_W = $clog2(MAX_KEYFRAMES + 1);
  localparam int IDX_W = $clog2(MAX_KEYFRAMES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEYFRAMES);
  localparam int LEN_W = pwl_pkg::LEN_W;
  localparam int POS_W = pwl_pkg::POS_W;

  pwl_pkg::vec3_t coord_mem [MAX_KEYFRAMES];
  logic [LEN_W-1:0] len_mem [MAX_KEYFRAMES];

  pwl_pkg::op_t        op_r;
  logic                restart_r;
  pwl_pkg::vec3_t      q_r, pa_r, pb_r, rd_c_r, rs_pt_r, out_pt_r;
  logic [POS_W-1:0]    t_r, total_r, acc_r, rs_found_r, out_found_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [pwl_pkg::TOL_W-1:0] tol_r;
  logic [IDX_W-1:0]    idx_r;
  logic [LEN_W-1:0]    seg_r, off_r, d1_r, rd_l_r;
  pwl_pkg::status_t    rs_status_r, out_status_r;

  logic [IDX_W-1:0]    rd_addr, last_idx;
  logic [CNT_W-1:0]    cnt_m1;
  logic [CNT_W:0]      idx_p2;
  logic [POS_W:0]      ev_sum, fnd_sum, seg_sum, tot_sum;
  logic [POS_W-1:0]    fnd_sat, seg_sat, tot_sat, t_off;
  logic [POS_W-1:0]    found_val;
  logic [LEN_W:0]      on_lhs, on_rhs;
  logic                a_done;
  logic [LEN_W-1:0]    a_dist;
  pwl_pkg::vec3_t      a_lerp;

  pwl_arith u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.arith_start),
    .op       (cmd.arith_op),
    .pa       (pa_r),
    .pb       (pb_r),
    .off      (off_r),
    .len      (seg_r),
    .done     (a_done),
    .dist_out (a_dist),
    .lerp     (a_lerp)
  );

  always_comb begin
    cnt_m1   = cnt_r - CNT_W'(1);
    last_idx = cnt_m1[IDX_W-1:0];
    unique case (cmd.rd_sel)
      pwl_pkg::RD_ZERO: rd_addr = '0;
      pwl_pkg::RD_LAST: rd_addr = last_idx;
      pwl_pkg::RD_IDX:  rd_addr = idx_r;
      pwl_pkg::RD_NEXT: rd_addr = idx_r + IDX_W'(1);
      default:          rd_addr = '0;
    endcase
    idx_p2    = (CNT_W+1)'(idx_r) + (CNT_W+1)'(2);
    ev_sum    = {1'b0, acc_r} + (POS_W+1)'(rd_l_r);
    fnd_sum   = {1'b0, acc_r} + (POS_W+1)'(d1_r);
    seg_sum   = {1'b0, acc_r} + (POS_W+1)'(seg_r);
    tot_sum   = {1'b0, total_r} + (POS_W+1)'(a_dist);
    fnd_sat   = fnd_sum[POS_W] ? '1 : fnd_sum[POS_W-1:0];
    seg_sat   = seg_sum[POS_W] ? '1 : seg_sum[POS_W-1:0];
    tot_sat   = tot_sum[POS_W] ? '1 : tot_sum[POS_W-1:0];
    t_off     = t_r - acc_r;
    on_lhs    = {1'b0, d1_r} + {1'b0, a_dist};
    on_rhs    = {1'b0, seg_r} + (LEN_W+1)'(tol_r);
    found_val = (seg_r < LEN_W'(tol_r)) ? acc_r : fnd_sat;

    sts.op         = op_r;
    sts.restart    = restart_r;
    sts.cnt_full   = cnt_r == CNT_MAX;
    sts.cnt_zero   = cnt_r == '0;
    sts.cnt_lt2    = cnt_r < CNT_W'(2);
    sts.t_zero     = t_r == '0;
    sts.t_ge_total = t_r >= total_r;
    sts.ev_hit     = ev_sum >= {1'b0, t_r};
    sts.on_seg     = on_lhs <= on_rhs;
    sts.last_seg   = idx_p2 >= {1'b0, cnt_r};
    sts.arith_done = a_done;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_kf) begin
      coord_mem[cnt_r[IDX_W-1:0]] <= q_r;
    end
    if (cmd.wr_len) begin
      len_mem[last_idx] <= a_dist;
    end
    rd_c_r <= coord_mem[rd_addr];
    rd_l_r <= len_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      total_r <= '0;
      tol_r   <= pwl_pkg::TOL_W'(1);
    end else begin
      if (cfg_we) tol_r <= cfg_tol;
      if (cmd.clr_path) begin
        cnt_r   <= '0;
        total_r <= '0;
      end else begin
        if (cmd.wr_len)  total_r <= tot_sat;
        if (cmd.cnt_inc) cnt_r   <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      op_r      <= pwl_pkg::op_t'(in_opcode);
      restart_r <= in_restart;
      q_r       <= {in_coord_z, in_coord_y, in_coord_x};
      t_r       <= in_arc_position;
    end
    if (cmd.ld_pa_q)  pa_r <= q_r;
    if (cmd.ld_pa_rd) pa_r <= rd_c_r;
    if (cmd.ld_pb_q)  pb_r <= q_r;
    if (cmd.ld_pb_rd) pb_r <= rd_c_r;
    if (cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + IDX_W'(1);
    if (cmd.acc_clr) acc_r <= '0;
    else if (cmd.acc_add_rd) acc_r <= ev_sum[POS_W-1:0];
    else if (cmd.acc_add_seg) acc_r <= seg_sat;
    if (cmd.seg_ld) seg_r <= rd_l_r;
    if (cmd.off_ld) off_r <= t_off[LEN_W-1:0];
    if (cmd.d1_ld)  d1_r  <= a_dist;
    if (cmd.res_ld) begin
      rs_status_r <= cmd.res_status;
      unique case (cmd.res_kind)
        pwl_pkg::RES_NONE: begin
          rs_pt_r    <= '0;
          rs_found_r <= '0;
        end
        pwl_pkg::RES_COORD: begin
          rs_pt_r    <= rd_c_r;
          rs_found_r <= '0;
        end
        pwl_pkg::RES_LERP: begin
          rs_pt_r    <= a_lerp;
          rs_found_r <= '0;
        end
        pwl_pkg::RES_FOUND: begin
          rs_pt_r    <= '0;
          rs_found_r <= found_val;
        end
        default: begin
          rs_pt_r    <= '0;
          rs_found_r <= '0;
        end
      endcase
    end
    if (cmd.out_ld) begin
      out_pt_r     <= rs_pt_r;
      out_found_r  <= rs_found_r;
      out_status_r <= rs_status_r;
    end
  end

  assign out_point_x        = out_pt_r[0];
  assign out_point_y        = out_pt_r[1];
  assign out_point_z        = out_pt_r[2];
  assign out_found_position = out_found_r;
  assign out_status         = out_status_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_MAX)
    else $error("keyframe count above store depth");
  a_wr_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_kf |-> !sts.cnt_full)
    else $error("keyframe written into a full store");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.idx_inc |-> !sts.last_seg)
    else $error("segment walk past last segment");
  a_arith_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.arith_start |=> !a_done)
    else $error("arith unit finished right after start");

endmodule

FILE: hw/rtl/pwl_ctrl.sv
// Controller state machine: handshakes and operation sequencing.
module pwl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pwl_pkg::pwl_sts_t sts,
  output pwl_pkg::pwl_cmd_t cmd
);

  pwl_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pwl_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = state_r != pwl_pkg::S_IDLE;
    unique case (state_r)
      pwl_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = pwl_pkg::S_DECODE;
        end
      end
      pwl_pkg::S_DECODE: begin
        unique case (sts.op)
          pwl_pkg::OP_NOP: state_nxt = pwl_pkg::S_IDLE;
          pwl_pkg::OP_APPEND: begin
            cmd.clr_path = sts.restart;
            state_nxt    = pwl_pkg::S_APP;
          end
          pwl_pkg::OP_EVAL: begin
            if (sts.cnt_lt2) begin
              cmd.res_ld     = 1'b1;
              cmd.res_kind   = pwl_pkg::RES_NONE;
              cmd.res_status = pwl_pkg::ST_SHORT;
              state_nxt      = pwl_pkg::S_OUT;
            end else if (sts.t_zero) begin
              cmd.rd_sel = pwl_pkg::RD_ZERO;
              state_nxt  = pwl_pkg::S_EV_END;
            end else if (sts.t_ge_total) begin
              cmd.rd_sel = pwl_pkg::RD_LAST;
              state_nxt  = pwl_pkg::S_EV_END;
            end else begin
              cmd.idx_clr = 1'b1;
              cmd.acc_clr = 1'b1;
              cmd.rd_sel  = pwl_pkg::RD_ZERO;
              state_nxt   = pwl_pkg::S_EV_WALK;
            end
          end
          pwl_pkg::OP_LOCATE: begin
            if (sts.cnt_lt2) begin
              cmd.res_ld     = 1'b1;
              cmd.res_kind   = pwl_pkg::RES_NONE;
              cmd.res_status = pwl_pkg::ST_SHORT;
              state_nxt      = pwl_pkg::S_OUT;
            end else begin
              cmd.idx_clr = 1'b1;
              cmd.acc_clr = 1'b1;
              cmd.rd_sel  = pwl_pkg::RD_ZERO;
              state_nxt   = pwl_pkg::S_LC_P0;
            end
          end
          default: state_nxt = pwl_pkg::S_IDLE;
        endcase
      end
      pwl_pkg::S_APP: begin
        cmd.res_kind = pwl_pkg::RES_NONE;
        if (sts.cnt_full) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = pwl_pkg::ST_FULL;
          state_nxt      = pwl_pkg::S_OUT;
        end else if (sts.cnt_zero) begin
          cmd.wr_kf      = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.res_ld     = 1'b1;
          cmd.res_status = pwl_pkg::ST_OK;
          state_nxt      = pwl_pkg::S_OUT;
        end else begin
          cmd.wr_kf  = 1'b1;
          cmd.rd_sel = pwl_pkg::RD_LAST;
          state_nxt  = pwl_pkg::S_APP_RD;
        end
      end
      pwl_pkg::S_APP_RD: begin
        cmd.ld_pa_rd = 1'b1;
        cmd.ld_pb_q  = 1'b1;
        state_nxt    = pwl_pkg::S_APP_GO;
      end
      pwl_pkg::S_APP_GO: begin
        cmd.arith_start = 1'b1;
        cmd.arith_op    = pwl_pkg::AR_DIST;
        state_nxt       = pwl_pkg::S_APP_WT;
      end
      pwl_pkg::S_APP_WT: begin
        if (sts.arith_done) begin
          cmd.wr_len     = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.res_ld     = 1'b1;
          cmd.res_kind   = pwl_pkg::RES_NONE;
          cmd.res_status = pwl_pkg::ST_OK;
          state_nxt      = pwl_pkg::S_OUT;
        end
      end
      pwl_pkg::S_EV_WALK: begin
        if (sts.ev_hit) begin
          cmd.seg_ld = 1'b1;
          cmd.off_ld = 1'b1;
          cmd.rd_sel = pwl_pkg::RD_IDX;
          state_nxt  = pwl_pkg::S_EV_A;
        end else begin
          cmd.acc_add_rd = 1'b1;
          cmd.idx_inc    = 1'b1;
          cmd.rd_sel     = pwl_pkg::RD_NEXT;
        end
      end
      pwl_pkg::S_EV_A: begin
        cmd.ld_pa_rd = 1'b1;
        cmd.rd_sel   = pwl_pkg::RD_NEXT;
        state_nxt    = pwl_pkg::S_EV_B;
      end
      pwl_pkg::S_EV_B: begin
        cmd.ld_pb_rd = 1'b1;
        state_nxt    = pwl_pkg::S_EV_GO;
      end
      pwl_pkg::S_EV_GO: begin
        cmd.arith_start = 1'b1;
        cmd.arith_op    = pwl_pkg::AR_LERP;
        state_nxt       = pwl_pkg::S_EV_WT;
      end
      pwl_pkg::S_EV_WT: begin
        if (sts.arith_done) begin
          cmd.res_ld     = 1'b1;
          cmd.res_kind   = pwl_pkg::RES_LERP;
          cmd.res_status = pwl_pkg::ST_OK;
          state_nxt      = pwl_pkg::S_OUT;
        end
      end
      pwl_pkg::S_EV_END: begin
        cmd.res_ld     = 1'b1;
        cmd.res_kind   = pwl_pkg::RES_COORD;
        cmd.res_status = pwl_pkg::ST_OK;
        state_nxt      = pwl_pkg::S_OUT;
      end
      pwl_pkg::S_LC_P0: begin
        cmd.ld_pa_q  = 1'b1;
        cmd.ld_pb_rd = 1'b1;
        state_nxt    = pwl_pkg::S_LC_D0;
      end
      pwl_pkg::S_LC_D0: begin
        cmd.arith_start = 1'b1;
        cmd.arith_op    = pwl_pkg::AR_DIST;
        state_nxt       = pwl_pkg::S_LC_W0;
      end
      pwl_pkg::S_LC_W0: begin
        if (sts.arith_done) begin
          cmd.d1_ld = 1'b1;
          state_nxt = pwl_pkg::S_LC_RL;
        end
      end
      pwl_pkg::S_LC_RL: begin
        cmd.rd_sel = pwl_pkg::RD_IDX;
        state_nxt  = pwl_pkg::S_LC_RC;
      end
      pwl_pkg::S_LC_RC: begin
        cmd.seg_ld = 1'b1;
        cmd.rd_sel = pwl_pkg::RD_NEXT;
        state_nxt  = pwl_pkg::S_LC_LD;
      end
      pwl_pkg::S_LC_LD: begin
        cmd.ld_pb_rd = 1'b1;
        state_nxt    = pwl_pkg::S_LC_GO;
      end
      pwl_pkg::S_LC_GO: begin
        cmd.arith_start = 1'b1;
        cmd.arith_op    = pwl_pkg::AR_DIST;
        state_nxt       = pwl_pkg::S_LC_WT;
      end
      pwl_pkg::S_LC_WT: begin
        if (sts.arith_done) begin
          if (sts.on_seg) begin
            cmd.res_ld     = 1'b1;
            cmd.res_kind   = pwl_pkg::RES_FOUND;
            cmd.res_status = pwl_pkg::ST_OK;
            state_nxt      = pwl_pkg::S_OUT;
          end else begin
            cmd.acc_add_seg = 1'b1;
            cmd.d1_ld       = 1'b1;
            if (sts.last_seg) begin
              cmd.res_ld     = 1'b1;
              cmd.res_kind   = pwl_pkg::RES_NONE;
              cmd.res_status = pwl_pkg::ST_NOT_ON_PATH;
              state_nxt      = pwl_pkg::S_OUT;
            end else begin
              cmd.idx_inc = 1'b1;
              state_nxt   = pwl_pkg::S_LC_RL;
            end
          end
        end
      end
      pwl_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld = 1'b1;
          state_nxt  = pwl_pkg::S_IDLE;
        end
      end
      default: state_nxt = pwl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_ld) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/piecewise_linear_path_eval.sv
// Top level of the piecewise-linear 3-D path evaluator.
//
// Input channel (in_valid / in_stall): one item carries an opcode (append,
// evaluate, locate, no-op), a restart flag, a Q16.16 point and a Q24.16 arc
// position. in_stall is low only while the controller is idle; one item is
// worked at a time. A no-op item gives no result.
// Result channel (out_valid / out_stall): point, found position and status.
// The result sits in an output register, so the next item is taken while a
// result still waits; a stalled result holds until taken, and the result
// after it waits in the controller with in_stall high.
// Work per item in the shared multiply/sqrt/divide unit; the next item can
// be taken in the same cycle that out_valid rises:
//   short path (evaluate or locate), first keyframe, full store: no arithmetic
//   append   one distance (6 multiply steps, 34 square-root steps)
//   evaluate no arithmetic when clamped, else a walk over the segments, then
//            3 axes of 2 multiply and 33 divide steps
//   locate   one distance to the first keyframe, then one per segment tested
// Configuration (cfg_valid / cfg_ready): on_line_tolerance, ready always;
// write only while idle.
// Reset (synchronous, rst_n low): empty path, tolerance 1, no result pending.
module piecewise_linear_path_eval #(
  parameter int MAX_KEYFRAMES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic                in_restart,
  input  logic signed [31:0]  in_coord_x,
  input  logic signed [31:0]  in_coord_y,
  input  logic signed [31:0]  in_coord_z,
  input  logic [39:0]         in_arc_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_point_x,
  output logic signed [31:0]  out_point_y,
  output logic signed [31:0]  out_point_z,
  output logic [39:0]         out_found_position,
  output logic [1:0]          out_status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_on_line_tolerance
);

  pwl_pkg::pwl_cmd_t cmd;
  pwl_pkg::pwl_sts_t sts;
  logic [31:0] px, py, pz;

  assign cfg_ready = 1'b1;

  pwl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pwl_dp #(.MAX_KEYFRAMES(MAX_KEYFRAMES)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_opcode),
    .in_restart         (in_restart),
    .in_coord_x         (in_coord_x),
    .in_coord_y         (in_coord_y),
    .in_coord_z         (in_coord_z),
    .in_arc_position    (in_arc_position),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_tol            (cfg_on_line_tolerance),
    .out_point_x        (px),
    .out_point_y        (py),
    .out_point_z        (pz),
    .out_found_position (out_found_position),
    .out_status         (out_status)
  );

  assign out_point_x = $signed(px);
  assign out_point_y = $signed(py);
  assign out_point_z = $signed(pz);

endmodule
